// File: design/lome_pkg.sv
// Shared types and constants of the order book engine.
`timescale 1ns / 1ps
`default_nettype none
package lome_pkg;

  localparam int unsigned ORDER_SLOTS = 32;
  localparam int unsigned IDX_W = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    KIND_TRADE     = 3'd0,
    KIND_ADD_DONE  = 3'd1,
    KIND_INVALID   = 3'd2,
    KIND_BOOK_FULL = 3'd3,
    KIND_CANCELLED = 3'd4,
    KIND_NOT_FOUND = 3'd5,
    KIND_FOUND     = 3'd6
  } lome_kind_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [30:0] order_id;
    logic        is_sell;
    logic        is_market;
    logic [30:0] limit_price;
    logic [30:0] order_quantity;
  } lome_in_t;

  typedef struct packed {
    lome_kind_e  kind;
    logic [31:0] trade_number;
    logic [30:0] buyer_id;
    logic [30:0] seller_id;
    logic [30:0] result_price;
    logic [30:0] result_quantity;
    logic        result_is_sell;
    logic        last;
  } lome_out_t;

  // search parameters, held steady during a pass
  typedef struct packed {
    logic [30:0] id;
    logic        sell;
    logic        mkt;
    logic [30:0] price;
    logic [31:0] arr;
  } lome_qry_t;

  // slot write broadcast from the controller
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic             valid;
    logic             qty_en;
    logic             load;
    logic [30:0]      qty;
    logic             sell;
    logic [30:0]      price;
    logic [30:0]      owner;
    logic [31:0]      age;
  } lome_wr_t;

  // search token passed down the chain
  typedef struct packed {
    logic             vld;
    logic             own_hit;
    logic [IDX_W-1:0] own_idx;
    logic [31:0]      own_el;
    logic [30:0]      own_price;
    logic [30:0]      own_qty;
    logic             own_sell;
    logic             m_hit;
    logic [IDX_W-1:0] m_idx;
    logic [31:0]      m_el;
    logic [30:0]      m_price;
    logic [30:0]      m_qty;
    logic [30:0]      m_owner;
    logic             f_hit;
    logic [IDX_W-1:0] f_idx;
  } lome_tok_t;

endpackage
`default_nettype wire

// File: design/lome_cell.sv
// One book slot: holds a resting order and folds it into the passing search token.
`timescale 1ns / 1ps
`default_nettype none
module lome_cell import lome_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [IDX_W-1:0] idx_i,
  input  wire lome_qry_t        qry_i,
  input  wire lome_wr_t         wr_i,
  input  wire lome_tok_t        tok_i,
  output lome_tok_t             tok_o
);

  logic        valid_q;
  logic        sell_q;
  logic [30:0] price_q;
  logic [30:0] qty_q;
  logic [30:0] owner_q;
  logic [31:0] age_q;
  logic        tok_vld_q;
  lome_tok_t   tok_q, tok_d;

  logic [31:0] el;
  logic        own_cand, m_cand, m_cross, m_better, hit;

  assign hit = wr_i.en && (wr_i.idx == idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (hit) begin
      valid_q <= wr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit && wr_i.qty_en) begin
      qty_q <= wr_i.qty;
    end
    if (hit && wr_i.load) begin
      sell_q  <= wr_i.sell;
      price_q <= wr_i.price;
      owner_q <= wr_i.owner;
      age_q   <= wr_i.age;
    end
  end

  always_comb begin
    el       = qry_i.arr - age_q;
    own_cand = valid_q && (owner_q == qry_i.id);
    m_cross  = qry_i.mkt || (qry_i.sell ? (price_q >= qry_i.price) : (price_q <= qry_i.price));
    m_cand   = valid_q && (sell_q != qry_i.sell) && m_cross;
    if (price_q != tok_i.m_price) begin
      m_better = qry_i.sell ? (price_q > tok_i.m_price) : (price_q < tok_i.m_price);
    end else begin
      m_better = el > tok_i.m_el;
    end

    tok_d = tok_i;
    if (own_cand && (!tok_i.own_hit || el > tok_i.own_el)) begin
      tok_d.own_hit   = 1'b1;
      tok_d.own_idx   = idx_i;
      tok_d.own_el    = el;
      tok_d.own_price = price_q;
      tok_d.own_qty   = qty_q;
      tok_d.own_sell  = sell_q;
    end
    if (m_cand && (!tok_i.m_hit || m_better)) begin
      tok_d.m_hit   = 1'b1;
      tok_d.m_idx   = idx_i;
      tok_d.m_el    = el;
      tok_d.m_price = price_q;
      tok_d.m_qty   = qty_q;
      tok_d.m_owner = owner_q;
    end
    // lowest free slot
    if (!tok_i.f_hit && !valid_q) begin
      tok_d.f_hit = 1'b1;
      tok_d.f_idx = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = tok_vld_q;
  end

endmodule
`default_nettype wire

// File: design/limit_order_matching_engine_core.sv
// Top level: request controller, result register and the chain of book slots.
`timescale 1ns / 1ps
`default_nettype none
// Single-instrument price-time order book with ORDER_SLOTS resting entries, one per cell
// of a slot chain. Every lookup (best match, oldest order of an id, lowest free slot)
// sends one token down the chain, one cell per cycle. A cancel, a query or a non-crossing
// add takes one pass; an add that fills k resting orders takes about k + 1 passes.
// Invalid requests are answered without a pass. A new request is taken once the previous
// one has handed its final result to the output register.
module limit_order_matching_engine_core import lome_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire lome_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output lome_out_t      out_data_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_START  = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  localparam logic [1:0] NX_IDLE   = 2'd0;
  localparam logic [1:0] NX_SEARCH = 2'd1;
  localparam logic [1:0] NX_DONE   = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [1:0]  next_q, next_d;
  lome_in_t    req_q, req_d;
  logic [30:0] qty_q, qty_d;
  logic [31:0] arr_q, arr_d;
  logic [31:0] trade_q, trade_d;
  lome_out_t   res_q, res_d;
  logic        out_valid_q, out_valid_d;
  lome_out_t   out_q, out_d;

  lome_qry_t   qry;
  lome_wr_t    wr;
  lome_tok_t   inj;
  lome_tok_t   tok [ORDER_SLOTS+1];
  lome_tok_t   tail;
  logic [30:0] fill;
  logic        out_free;

  assign qry.id    = req_q.order_id;
  assign qry.sell  = req_q.is_sell;
  assign qry.mkt   = req_q.is_market;
  assign qry.price = req_q.limit_price;
  assign qry.arr   = arr_q;

  always_comb begin
    inj     = '0;
    inj.vld = (state_q == ST_START);
  end

  assign tok[0] = inj;
  for (genvar k = 0; k < ORDER_SLOTS; k++) begin : g_slot
    lome_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDX_W'(k)),
      .qry_i  (qry),
      .wr_i   (wr),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end
  assign tail = tok[ORDER_SLOTS];

  assign out_free = !out_valid_q || out_ready_i;
  assign fill     = (qty_q < tail.m_qty) ? qty_q : tail.m_qty;

  always_comb begin
    state_d     = state_q;
    next_d      = next_q;
    req_d       = req_q;
    qty_d       = qty_q;
    arr_d       = arr_q;
    trade_d     = trade_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    wr          = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          qty_d = in_data_i.order_quantity;
          if (in_data_i.mode == MODE_CANCEL || in_data_i.mode == MODE_QUERY ||
              (in_data_i.mode == MODE_ADD && in_data_i.order_quantity != '0 &&
               (in_data_i.is_market || in_data_i.limit_price != '0))) begin
            state_d = ST_START;
          end else begin
            res_d      = '0;
            res_d.kind = KIND_INVALID;
            res_d.last = 1'b1;
            next_d     = NX_IDLE;
            state_d    = ST_EMIT;
          end
        end
      end
      ST_START: begin
        state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (tail.vld) begin
          res_d      = '0;
          res_d.last = 1'b1;
          next_d     = NX_IDLE;
          state_d    = ST_EMIT;
          if (req_q.mode != MODE_ADD) begin
            if (!tail.own_hit) begin
              res_d.kind = KIND_NOT_FOUND;
            end else if (req_q.mode == MODE_CANCEL) begin
              wr.en      = 1'b1;
              wr.idx     = tail.own_idx;
              wr.valid   = 1'b0;
              res_d.kind = KIND_CANCELLED;
            end else begin
              res_d.kind            = KIND_FOUND;
              res_d.result_price    = tail.own_price;
              res_d.result_quantity = tail.own_qty;
              res_d.result_is_sell  = tail.own_sell;
            end
          end else if (tail.m_hit) begin
            wr.en                 = 1'b1;
            wr.idx                = tail.m_idx;
            wr.qty_en             = 1'b1;
            wr.qty                = tail.m_qty - fill;
            wr.valid              = (tail.m_qty != fill);
            res_d.kind            = KIND_TRADE;
            res_d.trade_number    = trade_q;
            res_d.buyer_id        = req_q.is_sell ? tail.m_owner : req_q.order_id;
            res_d.seller_id       = req_q.is_sell ? req_q.order_id : tail.m_owner;
            res_d.result_price    = tail.m_price;
            res_d.result_quantity = fill;
            res_d.last            = 1'b0;
            trade_d               = trade_q + 32'd1;
            qty_d                 = qty_q - fill;
            next_d                = (qty_q != fill) ? NX_SEARCH : NX_DONE;
          end else begin
            res_d.result_quantity = qty_q;
            if (req_q.is_market) begin
              res_d.kind = KIND_ADD_DONE;
            end else if (tail.f_hit) begin
              wr.en      = 1'b1;
              wr.idx     = tail.f_idx;
              wr.valid   = 1'b1;
              wr.qty_en  = 1'b1;
              wr.load    = 1'b1;
              wr.qty     = qty_q;
              wr.sell    = req_q.is_sell;
              wr.price   = req_q.limit_price;
              wr.owner   = req_q.order_id;
              wr.age     = arr_q;
              arr_d      = arr_q + 32'd1;
              res_d.kind = KIND_ADD_DONE;
            end else begin
              res_d.kind = KIND_BOOK_FULL;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          case (next_q)
            NX_SEARCH: state_d = ST_START;
            NX_DONE: begin
              res_d                 = '0;
              res_d.kind            = KIND_ADD_DONE;
              res_d.result_quantity = qty_q;
              res_d.last            = 1'b1;
              next_d                = NX_IDLE;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      next_q      <= NX_IDLE;
      arr_q       <= '0;
      trade_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_q      <= next_d;
      arr_q       <= arr_d;
      trade_q     <= trade_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    qty_q <= qty_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_trade_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.kind == KIND_TRADE)
    else $error("non-final beat that is not a trade");

  a_write_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> state_q == ST_SEARCH)
    else $error("slot write outside a search");

  a_token_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.vld |-> state_q == ST_SEARCH)
    else $error("token left the chain outside a search");

  a_trade_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trade_q != $past(trade_q) |-> $past(res_d.kind == KIND_TRADE && state_q == ST_SEARCH))
    else $error("trade counter moved without a trade");

endmodule
`default_nettype wire
